[rtl/ihex_pkg.sv]
// ihex_pkg: shared types, constants and character functions of the hex record encoder
// no dependencies; used by the interfaces, controller, datapath and top level
package ihex_pkg;

  // payload widths
  localparam int DATA_W = 8;
  localparam int CHAR_W = 7;

  // default data record length in bytes
  localparam int RECORD_BYTES_DEF = 16;

  // character index within one section of a line
  localparam int IDX_W = 4;
  localparam logic [IDX_W-1:0] ADDR_LAST = 4'd15;  // ":02000004" 00 seg chk lf
  localparam logic [IDX_W-1:0] HEAD_LAST = 4'd8;   // ':' count addr "00"
  localparam logic [IDX_W-1:0] TAIL_LAST = 4'd2;   // chk lf
  localparam logic [IDX_W-1:0] EOF_LAST  = 4'd11;  // ":00000001FF" lf

  // character codes
  localparam logic [CHAR_W-1:0] CH_COLON = 7'h3A;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_ONE   = 7'h31;
  localparam logic [CHAR_W-1:0] CH_TWO   = 7'h32;
  localparam logic [CHAR_W-1:0] CH_FOUR  = 7'h34;
  localparam logic [CHAR_W-1:0] CH_F     = 7'h46;
  localparam logic [CHAR_W-1:0] CH_LF    = 7'h0A;

  // section of output text being sent
  typedef enum logic [2:0] {
    PH_ADDR,
    PH_HEAD,
    PH_BYTES,
    PH_TAIL,
    PH_EOF
  } phase_t;

  // controller to datapath
  typedef struct packed {
    logic             load;        // take the input item
    logic             emit;        // a character is due this cycle
    phase_t           phase;
    logic [IDX_W-1:0] idx;
    logic             last;        // final character for this item
    logic             clr_record;  // data record done
    logic             clr_image;   // end-of-file record done
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_addr;  // extended address record due before this byte
    logic flush;      // this byte closes a data record
    logic last;       // this byte ends the image
    logic adv;        // output stage can take a character
  } sts_t;

  // uppercase hex digit
  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] n);
    logic [CHAR_W-1:0] c;
    if (n < 4'd10) begin
      c = CH_ZERO + {3'b000, n};
    end else begin
      c = 7'h37 + {3'b000, n};
    end
    return c;
  endfunction

  // fixed head of the extended linear address record
  function automatic logic [CHAR_W-1:0] addr_fix_char(input logic [IDX_W-1:0] i);
    logic [CHAR_W-1:0] c;
    unique case (i)
      4'd0:    c = CH_COLON;
      4'd1:    c = CH_ZERO;
      4'd2:    c = CH_TWO;
      4'd8:    c = CH_FOUR;
      default: c = CH_ZERO;
    endcase
    return c;
  endfunction

  // end-of-file record text
  function automatic logic [CHAR_W-1:0] eof_char(input logic [IDX_W-1:0] i);
    logic [CHAR_W-1:0] c;
    unique case (i)
      4'd0:    c = CH_COLON;
      4'd8:    c = CH_ONE;
      4'd9:    c = CH_F;
      4'd10:   c = CH_F;
      4'd11:   c = CH_LF;
      default: c = CH_ZERO;
    endcase
    return c;
  endfunction

endpackage

[rtl/ihex_if.sv]
// ihex_if: valid/ready channel interfaces for the byte input and character output
// depends on ihex_pkg for payload widths
interface ihex_in_if;
  logic                        valid;
  logic                        ready;
  logic [ihex_pkg::DATA_W-1:0] data_byte;
  logic                        last_in;

  modport source (output valid, data_byte, last_in, input ready);
  modport sink (input valid, data_byte, last_in, output ready);
endinterface

interface ihex_out_if;
  logic                        valid;
  logic                        ready;
  logic [ihex_pkg::CHAR_W-1:0] ascii_char;
  logic                        last_char;

  modport source (output valid, ascii_char, last_char, input ready);
  modport sink (input valid, ascii_char, last_char, output ready);
endinterface

[rtl/ihex_ctrl.sv]
// ihex_ctrl: sequencer walking the sections of each record, one character a cycle
// unless output stalls; depends on ihex_pkg, drives ihex_dp via cmd_t, reads sts_t
module ihex_ctrl #(
  parameter int RECORD_BYTES = ihex_pkg::RECORD_BYTES_DEF,
  localparam int CNT_W = $clog2(RECORD_BYTES + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ihex_pkg::sts_t     sts,
  input  logic [CNT_W-1:0]   count,
  output ihex_pkg::cmd_t     cmd,
  output logic [CNT_W-1:0]   byte_idx
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADDR,
    S_HEAD,
    S_BYTES,
    S_TAIL,
    S_EOF
  } state_t;

  // one step of the character index
  localparam logic [ihex_pkg::IDX_W-1:0] IDX_STEP = {{(ihex_pkg::IDX_W-1){1'b0}}, 1'b1};

  state_t                    state;
  logic [ihex_pkg::IDX_W-1:0] idx;
  logic                      flush_pend;
  logic                      last_pend;
  logic                      at_end;

  assign in_ready = (state == S_IDLE);

  // end of the current section on this cycle's character
  always_comb begin
    unique case (state)
      S_ADDR:  at_end = (idx == ihex_pkg::ADDR_LAST);
      S_HEAD:  at_end = (idx == ihex_pkg::HEAD_LAST);
      S_BYTES: at_end = idx[0] && (byte_idx + CNT_W'(1) == count);
      S_TAIL:  at_end = (idx == ihex_pkg::TAIL_LAST);
      S_EOF:   at_end = (idx == ihex_pkg::EOF_LAST);
      default: at_end = 1'b0;
    endcase
  end

  // command decode
  always_comb begin
    cmd.load       = in_valid && (state == S_IDLE);
    cmd.emit       = (state != S_IDLE);
    cmd.idx        = idx;
    cmd.clr_record = (state == S_TAIL) && at_end && sts.adv;
    cmd.clr_image  = (state == S_EOF) && at_end && sts.adv;
    cmd.last       = ((state == S_ADDR) && at_end && !flush_pend) ||
                     ((state == S_TAIL) && at_end && !last_pend) ||
                     ((state == S_EOF) && at_end);
    unique case (state)
      S_ADDR:  cmd.phase = ihex_pkg::PH_ADDR;
      S_HEAD:  cmd.phase = ihex_pkg::PH_HEAD;
      S_BYTES: cmd.phase = ihex_pkg::PH_BYTES;
      S_TAIL:  cmd.phase = ihex_pkg::PH_TAIL;
      S_EOF:   cmd.phase = ihex_pkg::PH_EOF;
      default: cmd.phase = ihex_pkg::PH_ADDR;
    endcase
  end

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      idx        <= '0;
      byte_idx   <= '0;
      flush_pend <= 1'b0;
      last_pend  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            flush_pend <= sts.flush;
            last_pend  <= sts.last;
            idx        <= '0;
            byte_idx   <= '0;
            if (sts.need_addr) begin
              state <= S_ADDR;
            end else if (sts.flush) begin
              state <= S_HEAD;
            end
          end
        end
        S_ADDR: begin
          if (sts.adv) begin
            if (at_end) begin
              idx   <= '0;
              state <= flush_pend ? S_HEAD : S_IDLE;
            end else begin
              idx <= idx + IDX_STEP;
            end
          end
        end
        S_HEAD: begin
          if (sts.adv) begin
            if (at_end) begin
              idx   <= '0;
              state <= S_BYTES;
            end else begin
              idx <= idx + IDX_STEP;
            end
          end
        end
        S_BYTES: begin
          if (sts.adv) begin
            if (idx[0]) begin
              idx <= '0;
              if (at_end) begin
                byte_idx <= '0;
                state    <= S_TAIL;
              end else begin
                byte_idx <= byte_idx + CNT_W'(1);
              end
            end else begin
              idx <= idx + IDX_STEP;
            end
          end
        end
        S_TAIL: begin
          if (sts.adv) begin
            if (at_end) begin
              idx   <= '0;
              state <= last_pend ? S_EOF : S_IDLE;
            end else begin
              idx <= idx + IDX_STEP;
            end
          end
        end
        S_EOF: begin
          if (sts.adv) begin
            if (at_end) begin
              idx       <= '0;
              last_pend <= 1'b0;
              state     <= S_IDLE;
            end else begin
              idx <= idx + IDX_STEP;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // buffer walk stays inside the held bytes
  a_byte_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_BYTES) |-> (byte_idx < count))
    else $error("byte index beyond held bytes");

  // end-of-file record only after the final byte
  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_EOF) |-> last_pend)
    else $error("end-of-file record without final byte");

  // final byte always closes a data record
  a_last_flush: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE && last_pend) |-> flush_pend)
    else $error("final byte without data record");

  // a byte that causes no text leaves the sequencer idle
  a_quiet_byte: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && !sts.need_addr && !sts.flush) |=> (state == S_IDLE))
    else $error("quiet byte left sequencer busy");

endmodule

[rtl/ihex_dp.sv]
// ihex_dp: record buffer, address and checksum registers, character select, output stage
// depends on ihex_pkg; commanded by ihex_ctrl
module ihex_dp #(
  parameter int RECORD_BYTES = ihex_pkg::RECORD_BYTES_DEF,
  localparam int CNT_W  = $clog2(RECORD_BYTES + 1),
  localparam int BIDX_W = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ihex_pkg::cmd_t              cmd,
  output ihex_pkg::sts_t              sts,
  output logic [CNT_W-1:0]            count,
  input  logic [CNT_W-1:0]            byte_idx,
  input  logic [ihex_pkg::DATA_W-1:0] data_byte,
  input  logic                        last_in,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [ihex_pkg::CHAR_W-1:0] ascii_char,
  output logic                        last_char
);

  logic [7:0]                  line_buf [RECORD_BYTES];
  logic [31:0]                 pos;
  logic [15:0]                 rec_addr;
  logic [7:0]                  sum;
  logic [1:0]                  seg;
  logic [7:0]                  cnt8;
  logic [7:0]                  rec_chk;
  logic [7:0]                  addr_chk;
  logic [7:0]                  rd_byte;
  logic [ihex_pkg::CHAR_W-1:0] ch;

  // status towards the sequencer
  always_comb begin
    sts.need_addr = (pos[15:0] == 16'h0000) && (pos[31:18] == 14'd0);
    sts.flush     = (count == CNT_W'(RECORD_BYTES - 1)) || last_in;
    sts.last      = last_in;
    sts.adv       = !out_valid || out_ready;
  end

  // record buffer, no reset
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      line_buf[count[BIDX_W-1:0]] <= data_byte;
    end
  end

  // record and image state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      count    <= '0;
      sum      <= '0;
      rec_addr <= '0;
      seg      <= '0;
    end else begin
      if (cmd.load) begin
        seg   <= pos[17:16];
        pos   <= pos + 32'd1;
        count <= count + CNT_W'(1);
        if (count == '0) begin
          rec_addr <= pos[15:0];
          sum      <= data_byte;
        end else begin
          sum <= sum + data_byte;
        end
      end
      if (cmd.clr_record || cmd.clr_image) begin
        count <= '0;
        sum   <= '0;
      end
      if (cmd.clr_image) begin
        pos <= '0;
      end
    end
  end

  // checksums
  assign cnt8     = {{(8 - CNT_W){1'b0}}, count};
  assign rec_chk  = 8'd0 - (sum + cnt8 + rec_addr[7:0] + rec_addr[15:8]);
  assign addr_chk = 8'd0 - (8'd6 + {6'd0, seg});
  assign rd_byte  = line_buf[byte_idx[BIDX_W-1:0]];

  // character select
  always_comb begin
    unique case (cmd.phase)
      ihex_pkg::PH_ADDR: begin
        unique case (cmd.idx)
          4'd12:   ch = ihex_pkg::hex_char({2'b00, seg});
          4'd13:   ch = ihex_pkg::hex_char(addr_chk[7:4]);
          4'd14:   ch = ihex_pkg::hex_char(addr_chk[3:0]);
          4'd15:   ch = ihex_pkg::CH_LF;
          default: ch = ihex_pkg::addr_fix_char(cmd.idx);
        endcase
      end
      ihex_pkg::PH_HEAD: begin
        unique case (cmd.idx)
          4'd0:    ch = ihex_pkg::CH_COLON;
          4'd1:    ch = ihex_pkg::hex_char(cnt8[7:4]);
          4'd2:    ch = ihex_pkg::hex_char(cnt8[3:0]);
          4'd3:    ch = ihex_pkg::hex_char(rec_addr[15:12]);
          4'd4:    ch = ihex_pkg::hex_char(rec_addr[11:8]);
          4'd5:    ch = ihex_pkg::hex_char(rec_addr[7:4]);
          4'd6:    ch = ihex_pkg::hex_char(rec_addr[3:0]);
          default: ch = ihex_pkg::CH_ZERO;
        endcase
      end
      ihex_pkg::PH_BYTES: begin
        ch = cmd.idx[0] ? ihex_pkg::hex_char(rd_byte[3:0])
                        : ihex_pkg::hex_char(rd_byte[7:4]);
      end
      ihex_pkg::PH_TAIL: begin
        unique case (cmd.idx)
          4'd0:    ch = ihex_pkg::hex_char(rec_chk[7:4]);
          4'd1:    ch = ihex_pkg::hex_char(rec_chk[3:0]);
          default: ch = ihex_pkg::CH_LF;
        endcase
      end
      ihex_pkg::PH_EOF: ch = ihex_pkg::eof_char(cmd.idx);
      default:          ch = ihex_pkg::CH_LF;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (sts.adv) begin
      out_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (sts.adv && cmd.emit) begin
      ascii_char <= ch;
      last_char  <= cmd.last;
    end
  end

endmodule

[rtl/intel_hex_record_encoder.sv]
// intel_hex_record_encoder: top level joining sequencer and datapath to the channels
// depends on ihex_pkg, ihex_in_if, ihex_out_if, ihex_ctrl and ihex_dp
//
//   channel  dir  payload                 meaning
//   in_ch    in   data_byte[7:0],last_in  image bytes in address order
//   out_ch   out  ascii_char[6:0],last_char  hex text, one character per transfer
//
// one input transfer is taken only while the sequencer is idle
// each record is then sent as characters: 16 per address record, 12 + 2n per data
// record of n bytes, 12 for the end-of-file record
// a byte that emits nothing returns to idle after its transfer cycle
// rst is synchronous; no clearing pass, the record buffer needs no reset
// a stalled out_ch holds the output register and freezes the sequencer
module intel_hex_record_encoder #(
  parameter int RECORD_BYTES = ihex_pkg::RECORD_BYTES_DEF,
  localparam int CNT_W = $clog2(RECORD_BYTES + 1)
) (
  input  logic       clk,
  input  logic       rst,
  ihex_in_if.sink    in_ch,
  ihex_out_if.source out_ch
);

  ihex_pkg::cmd_t   cmd;
  ihex_pkg::sts_t   sts;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] byte_idx;

  // sequencer
  ihex_ctrl #(
    .RECORD_BYTES (RECORD_BYTES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .count    (count),
    .cmd      (cmd),
    .byte_idx (byte_idx)
  );

  // datapath and output stage
  ihex_dp #(
    .RECORD_BYTES (RECORD_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .count      (count),
    .byte_idx   (byte_idx),
    .data_byte  (in_ch.data_byte),
    .last_in    (in_ch.last_in),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .ascii_char (out_ch.ascii_char),
    .last_char  (out_ch.last_char)
  );

endmodule

[tb/sv/ihex_tb_pkg.sv]
`timescale 1ns / 1ps
// ihex_tb_pkg: scoreboard for the hex record encoder testbench, predicts the text of each byte
// depends on ihex_pkg for payload widths and the default record length
package ihex_tb_pkg;
  import ihex_pkg::*;

  // one expected character of hex text
  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  class hex_text_scoreboard;
    int         errors;
    int         chars_seen;
    text_char_t expected_text[$];
    text_char_t fresh[$];
    string      digits = "0123456789ABCDEF";

    // image state as the encoder should hold it
    bit [7:0]  pend_bytes[RECORD_BYTES_DEF];
    int        pend_count;
    bit [15:0] pend_addr;
    bit [31:0] image_offset;
    bit [7:0]  pend_sum;

    function new();
      errors = 0;
      chars_seen = 0;
      clear_image();
    endfunction

    function void clear_image();
      pend_count = 0;
      pend_addr = 16'h0000;
      image_offset = 32'h0000_0000;
      pend_sum = 8'h00;
    endfunction

    function int pending();
      return expected_text.size();
    endfunction

    function void put_char(byte c);
      text_char_t t;
      t.ch = c[6:0];
      t.last = 1'b0;
      fresh.push_back(t);
    endfunction

    function void put_text(string s);
      for (int i = 0; i < s.len(); i++) put_char(s[i]);
    endfunction

    function void put_hex(bit [7:0] v);
      put_char(digits[v[7:4]]);
      put_char(digits[v[3:0]]);
    endfunction

    // work out the text that one accepted byte causes
    function void note_byte(logic [DATA_W-1:0] b, logic l);
      bit [7:0] seg;
      bit [7:0] total;
      fresh.delete();

      // extended linear address record on each 64k boundary below 0x40000
      if (image_offset[15:0] == 16'h0000 && image_offset < 32'h0004_0000) begin
        seg = image_offset[23:16];
        put_text(":02000004");
        put_hex(8'h00);
        put_hex(seg);
        put_hex(8'h00 - (8'h06 + seg));
        put_text("\n");
      end

      // collect the byte into the pending data record
      if (pend_count == 0) begin
        pend_addr = image_offset[15:0];
        pend_sum = 8'h00;
      end
      if (pend_count < RECORD_BYTES_DEF) begin
        pend_bytes[pend_count] = b;
        pend_count++;
      end
      pend_sum += b;

      // data record when full or at the end of the image
      if (pend_count >= RECORD_BYTES_DEF || l) begin
        total = pend_sum + 8'(pend_count) + pend_addr[7:0] + pend_addr[15:8];
        put_text(":");
        put_hex(8'(pend_count));
        put_hex(pend_addr[15:8]);
        put_hex(pend_addr[7:0]);
        put_text("00");
        for (int i = 0; i < pend_count; i++) put_hex(pend_bytes[i]);
        put_hex(8'h00 - total);
        put_text("\n");
        pend_count = 0;
        pend_sum = 8'h00;
      end

      image_offset++;

      // end-of-file record, then a fresh image
      if (l) begin
        put_text(":00000001FF\n");
        clear_image();
      end

      if (fresh.size() > 0) fresh[$].last = 1'b1;
      foreach (fresh[i]) expected_text.push_back(fresh[i]);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("mismatch: %s", msg);
    endtask

    // compare one character transfer with the oldest expectation
    task check_char(logic [CHAR_W-1:0] c, logic l);
      text_char_t want;
      chars_seen++;
      if (expected_text.size() == 0) begin
        report($sformatf("char %0d: %02h/%0b with nothing expected", chars_seen, c, l));
        return;
      end
      want = expected_text.pop_front();
      if (c !== want.ch) begin
        report($sformatf("char %0d: ascii_char %02h, want %02h", chars_seen, c, want.ch));
      end
      if (l !== want.last) begin
        report($sformatf("char %0d: last_char %0b, want %0b", chars_seen, l, want.last));
      end
    endtask
  endclass

endpackage

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// testbench: drives memory images into intel_hex_record_encoder and checks the hex text
// depends on ihex_pkg, ihex_if, ihex_tb_pkg and the encoder rtl
module testbench;
  import ihex_pkg::*;
  import ihex_tb_pkg::*;

  typedef enum int {
    STALL_NONE,
    STALL_PATTERN,
    STALL_RANDOM,
    STALL_LONG
  } stall_t;

  localparam int RANDOM_ITEMS = 500;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ihex_in_if  in_ch ();
  ihex_out_if out_ch ();

  intel_hex_record_encoder DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  hex_text_scoreboard hex_sb = new();

  stall_t stall_mode = STALL_NONE;
  bit     idle_on = 1'b0;
  int     burst_left = 0;
  int     bytes_sent = 0;

  always #1 clk = ~clk;

  // send one byte, with a random gap between bursts when idling is on
  task automatic push_byte(input logic [DATA_W-1:0] b, input logic l);
    int gap;
    if (idle_on && burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_in   <= l;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    hex_sb.note_byte(b, l);
    bytes_sent++;
    @(negedge clk);
  endtask

  // one image of random bytes, last byte marked
  task automatic push_image(input int len);
    for (int n = 0; n < len; n++) push_byte(8'($urandom_range(0, 255)), n == len - 1);
  endtask

  // receiver stall patterns
  initial begin
    int tick;
    tick = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      case (stall_mode)
        STALL_NONE: begin
          out_ch.ready <= 1'b1;
        end
        STALL_PATTERN: begin
          out_ch.ready <= (tick % 11 != 3) && (tick % 11 != 4) && (tick % 13 != 0);
        end
        STALL_RANDOM: begin
          out_ch.ready <= ($urandom_range(0, 2) != 0);
        end
        default: begin
          out_ch.ready <= (tick % 64 >= 20);
        end
      endcase
    end
  end

  // check every character transfer
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      hex_sb.check_char(out_ch.ascii_char, out_ch.last_char);
    end
  end

  // stimulus
  initial begin
    int len;
    int guard;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_in = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: one-byte image, full record with every nibble, short partial record
    idle_on = 1'b1;
    stall_mode = STALL_PATTERN;
    push_byte(8'hFF, 1'b1);
    for (int i = 0; i < 16; i++) push_byte(8'(i * 17), i == 15);
    push_byte(8'h80, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h01, 1'b1);

    // random images of mixed lengths under mixed idling
    while (bytes_sent < RANDOM_ITEMS) begin
      stall_mode = stall_t'($urandom_range(0, 3));
      idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0:       len = 1;
        7, 8:    len = $urandom_range(41, 80);
        9:       len = 16 * $urandom_range(1, 3);
        default: len = $urandom_range(2, 40);
      endcase
      push_image(len);
    end
    in_ch.valid <= 1'b0;

    // drain
    guard = 0;
    while (hex_sb.pending() > 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
    if (hex_sb.pending() > 0) begin
      hex_sb.report($sformatf("%0d expected characters never arrived", hex_sb.pending()));
    end
    if (hex_sb.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #20_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
